@@ rtl/core/kim_pkg.sv @@
// Package for the keyword intent matcher: window size, keyword table,
// event and motion codes and the drive settings per motion.
// No dependencies; imported by kim_match and keyword_intent_matcher_unit.
package kim_pkg;

  // Number of folded bytes kept in the character window.
  localparam int WINDOW_LEN = 8;
  localparam int KW_COUNT   = 16;
  localparam int KW_MAX     = 8;
  localparam int EV_GROUPS  = 11;

  // Window: element 0 holds the newest byte.
  typedef logic [WINDOW_LEN-1:0][7:0] win_t;
  typedef logic [EV_GROUPS-1:0]       flags_t;
  typedef logic [KW_MAX*8-1:0]        kw_text_t;

  // Event codes.
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_STOP     = 4'd1;
  localparam logic [3:0] EV_FORWARD  = 4'd2;
  localparam logic [3:0] EV_BACKWARD = 4'd3;
  localparam logic [3:0] EV_LEFT     = 4'd4;
  localparam logic [3:0] EV_RIGHT    = 4'd5;
  localparam logic [3:0] EV_LISTEN   = 4'd6;
  localparam logic [3:0] EV_THINK    = 4'd7;
  localparam logic [3:0] EV_SPEAK    = 4'd8;
  localparam logic [3:0] EV_CHARGE   = 4'd9;
  localparam logic [3:0] EV_SLEEP    = 4'd10;
  localparam logic [3:0] EV_ERROR    = 4'd11;

  // Motion codes.
  localparam logic [2:0] MO_NONE     = 3'd0;
  localparam logic [2:0] MO_FORWARD  = 3'd1;
  localparam logic [2:0] MO_BACKWARD = 3'd2;
  localparam logic [2:0] MO_LEFT     = 3'd3;
  localparam logic [2:0] MO_RIGHT    = 3'd4;

  // Drive speed in percent and motion time in milliseconds.
  localparam logic [6:0] SPD_DEFAULT  = 7'd40;
  localparam logic [6:0] SPD_BACKWARD = 7'd35;
  localparam logic [6:0] SPD_TURN     = 7'd30;
  localparam logic [9:0] DUR_DEFAULT  = 10'd500;
  localparam logic [9:0] DUR_BACKWARD = 10'd400;
  localparam logic [9:0] DUR_TURN     = 10'd350;

  // Letter folding bounds.
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE_OFS = 8'h20;

  // Keywords, right-aligned: the last character sits in the low byte,
  // so byte i lines up with window element i.
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "stop",   "tingzhi", "forward", "qianjin",
    "back",   "houtui",  "left",    "zuozhuan",
    "right",  "youzhuan","listen",  "think",
    "speak",  "charge",  "sleep",   "error"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd7, 4'd7, 4'd7, 4'd4, 4'd6, 4'd4, 4'd8,
    4'd5, 4'd8, 4'd6, 4'd5, 4'd5, 4'd6, 4'd5, 4'd5
  };

  // Flag bit set by each keyword (event code minus one).
  localparam logic [3:0] KW_FLAG [KW_COUNT] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
  };

endpackage

@@ rtl/core/kim_match.sv @@
// Parallel keyword compare against the tail of the character window.
// Depends on kim_pkg for the window type and the keyword table.
module kim_match
  import kim_pkg::*;
(
  input  win_t   win,
  output flags_t hits
);

  logic [KW_COUNT-1:0] kw_same;

  // Each keyword is compared over its own length; the groups are ORed.
  always_comb begin
    hits = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_same[k] = 1'b1;
      for (int i = 0; i < KW_MAX; i++) begin
        if ((i < int'(KW_LEN[k])) && (win[i] != KW_TEXT[k][8*i +: 8])) begin
          kw_same[k] = 1'b0;
        end
      end
      if (kw_same[k]) begin
        hits[KW_FLAG[k]] = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/keyword_intent_matcher_unit.sv @@
// Keyword intent matcher: input register, one processing stage, result register.
// A result is registered when its last byte leaves the input register.
// Throughput: one byte per cycle unless stalled; all keywords compare in parallel.
// A waiting result stalls only a last byte; other bytes keep flowing.
// Reset (rst_n low, synchronous) empties the window and clears the flags.
// Depends on kim_pkg and kim_match.
module keyword_intent_matcher_unit
  import kim_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_event_code,
  output logic [2:0] out_motion_code,
  output logic [6:0] out_speed_pct,
  output logic [9:0] out_move_ms
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  win_t       win_r, win_nxt, win_shift;
  flags_t     flags_r, flags_nxt, flags_upd, hits;
  logic       ended_r, ended_nxt;
  logic       take_byte;
  logic       adv;
  logic [7:0] folded;
  logic [3:0] ev;
  logic [2:0] motion;
  logic [6:0] speed;
  logic [9:0] dur;
  logic       out_valid_r;
  logic [3:0] out_event_r;
  logic [2:0] out_motion_r;
  logic [6:0] out_speed_r;
  logic [9:0] out_dur_r;

  // The stage moves on unless a last byte meets a result still waiting.
  assign adv      = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // Fold upper-case letters and shift the byte into the window.
  always_comb begin
    folded = in_byte_r;
    if ((in_byte_r >= CH_UPPER_A) && (in_byte_r <= CH_UPPER_Z)) begin
      folded = in_byte_r + CH_CASE_OFS;
    end
  end

  assign take_byte = !ended_r && (in_byte_r != 8'd0);
  assign win_shift = {win_r[WINDOW_LEN-2:0], folded};

  kim_match u_match (
    .win  (win_shift),
    .hits (hits)
  );

  assign flags_upd = take_byte ? (flags_r | hits) : flags_r;

  // Highest-priority set flag gives the event; stop wins.
  always_comb begin
    ev = EV_NONE;
    for (int g = EV_GROUPS; g >= 1; g--) begin
      if (flags_upd[g-1]) begin
        ev = 4'(g);
      end
    end
  end

  // Motion, speed and duration follow from the event.
  always_comb begin
    motion = MO_NONE;
    speed  = SPD_DEFAULT;
    dur    = DUR_DEFAULT;
    unique case (ev)
      EV_FORWARD: begin
        motion = MO_FORWARD;
      end
      EV_BACKWARD: begin
        motion = MO_BACKWARD;
        speed  = SPD_BACKWARD;
        dur    = DUR_BACKWARD;
      end
      EV_LEFT: begin
        motion = MO_LEFT;
        speed  = SPD_TURN;
        dur    = DUR_TURN;
      end
      EV_RIGHT: begin
        motion = MO_RIGHT;
        speed  = SPD_TURN;
        dur    = DUR_TURN;
      end
      default: begin
        motion = MO_NONE;
      end
    endcase
  end

  // Next text state; a last byte returns everything to the reset state.
  always_comb begin
    win_nxt   = win_r;
    flags_nxt = flags_r;
    ended_nxt = ended_r;
    if (adv) begin
      if (in_last_r) begin
        win_nxt   = '0;
        flags_nxt = '0;
        ended_nxt = 1'b0;
      end else begin
        flags_nxt = flags_upd;
        if (take_byte) begin
          win_nxt = win_shift;
        end else begin
          ended_nxt = 1'b1;
        end
      end
    end
  end

  // Control and text state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
      flags_r     <= '0;
      ended_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      win_r   <= win_nxt;
      flags_r <= flags_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_text_byte;
      in_last_r <= in_is_last;
    end
    if (adv && in_last_r) begin
      out_event_r  <= ev;
      out_motion_r <= motion;
      out_speed_r  <= speed;
      out_dur_r    <= dur;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = out_event_r;
  assign out_motion_code = out_motion_r;
  assign out_speed_pct   = out_speed_r;
  assign out_move_ms     = out_dur_r;

`ifndef SYNTHESIS
  // A stall on the input side only comes from a last byte behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && in_last_r && out_valid_r))
    else $error("input stalled without a waiting result");

  // After a last byte the text state is back at reset.
  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (flags_r == '0 && !ended_r && win_r == '0))
    else $error("text state not cleared after last byte");

  // A last byte always produces a result.
  a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> out_valid_r)
    else $error("last byte produced no result");

  // A motion only comes with a drive event.
  a_motion_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_motion_r != MO_NONE) |->
      (out_event_r == EV_FORWARD || out_event_r == EV_BACKWARD ||
       out_event_r == EV_LEFT || out_event_r == EV_RIGHT))
    else $error("motion without a drive event");
`endif

endmodule

@@ tb/tb_keyword_intent_matcher_unit.sv @@
// Self-checking testbench for keyword_intent_matcher_unit: byte texts go in,
// one intent result per text comes out and is checked against a predictor.
// Depends on kim_pkg (codes and drive settings) and the RTL of the block.
module tb_keyword_intent_matcher_unit
  import kim_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected intent of one text.
  typedef struct packed {
    logic [3:0] event_code;
    logic [2:0] motion_code;
    logic [6:0] speed_pct;
    logic [9:0] move_ms;
  } intent_t;

  // Predicts the intent of each text and checks the block's results in order.
  class intent_scoreboard;
    string      kw_word [KW_COUNT];
    logic [3:0] kw_event [KW_COUNT];
    win_t       text_window;
    flags_t     group_hits;
    bit         text_done;
    intent_t    pending_intents [$];
    int         mismatches;

    function new();
      kw_word = '{"stop", "tingzhi", "forward", "qianjin", "back", "houtui",
                  "left", "zuozhuan", "right", "youzhuan", "listen", "think",
                  "speak", "charge", "sleep", "error"};
      kw_event = '{EV_STOP, EV_STOP, EV_FORWARD, EV_FORWARD, EV_BACKWARD,
                   EV_BACKWARD, EV_LEFT, EV_LEFT, EV_RIGHT, EV_RIGHT, EV_LISTEN,
                   EV_THINK, EV_SPEAK, EV_CHARGE, EV_SLEEP, EV_ERROR};
      clear_text();
      mismatches = 0;
    endfunction

    function void clear_text();
      text_window = '0;
      group_hits  = '0;
      text_done   = 1'b0;
    endfunction

    // Fold the byte, shift it in and compare the window tail with every keyword.
    function void shift_in(logic [7:0] raw);
      logic [7:0] folded;
      int         wlen;
      bit         same;
      folded = raw;
      if (raw >= CH_UPPER_A && raw <= CH_UPPER_Z) begin
        folded = raw + CH_CASE_OFS;
      end
      text_window = {text_window[WINDOW_LEN-2:0], folded};
      for (int k = 0; k < KW_COUNT; k++) begin
        wlen = kw_word[k].len();
        same = (wlen <= WINDOW_LEN);
        for (int i = 0; same && i < wlen; i++) begin
          if (text_window[i] != 8'(kw_word[k][wlen-1-i])) begin
            same = 1'b0;
          end
        end
        if (same) begin
          group_hits[kw_event[k] - 4'd1] = 1'b1;
        end
      end
    endfunction

    // Note one accepted byte; a last byte queues the intent of the text.
    function void note_byte(logic [7:0] raw, logic last);
      intent_t want;
      if (!text_done) begin
        if (raw == 8'h00) begin
          text_done = 1'b1;
        end else begin
          shift_in(raw);
        end
      end
      if (last) begin
        want.event_code = EV_NONE;
        for (int g = EV_GROUPS - 1; g >= 0; g--) begin
          if (group_hits[g]) begin
            want.event_code = 4'(g + 1);
          end
        end
        want.motion_code = MO_NONE;
        want.speed_pct   = SPD_DEFAULT;
        want.move_ms     = DUR_DEFAULT;
        case (want.event_code)
          EV_FORWARD: begin
            want.motion_code = MO_FORWARD;
          end
          EV_BACKWARD: begin
            want.motion_code = MO_BACKWARD;
            want.speed_pct   = SPD_BACKWARD;
            want.move_ms     = DUR_BACKWARD;
          end
          EV_LEFT: begin
            want.motion_code = MO_LEFT;
            want.speed_pct   = SPD_TURN;
            want.move_ms     = DUR_TURN;
          end
          EV_RIGHT: begin
            want.motion_code = MO_RIGHT;
            want.speed_pct   = SPD_TURN;
            want.move_ms     = DUR_TURN;
          end
          default: begin
          end
        endcase
        pending_intents.push_back(want);
        clear_text();
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    // Compare one transferred result with the oldest expected intent.
    task check_intent(intent_t got);
      intent_t want;
      if (pending_intents.size() == 0) begin
        report_mismatch($sformatf("result ev=%0d with no text outstanding",
                                  got.event_code));
        return;
      end
      want = pending_intents.pop_front();
      if (got.event_code != want.event_code) begin
        report_mismatch($sformatf("event_code %0d, expected %0d",
                                  got.event_code, want.event_code));
      end
      if (got.motion_code != want.motion_code) begin
        report_mismatch($sformatf("motion_code %0d, expected %0d",
                                  got.motion_code, want.motion_code));
      end
      if (got.speed_pct != want.speed_pct) begin
        report_mismatch($sformatf("speed_pct %0d, expected %0d",
                                  got.speed_pct, want.speed_pct));
      end
      if (got.move_ms != want.move_ms) begin
        report_mismatch($sformatf("move_ms %0d, expected %0d",
                                  got.move_ms, want.move_ms));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_text_byte;
  logic       in_is_last;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_event_code;
  logic [2:0] out_motion_code;
  logic [6:0] out_speed_pct;
  logic [9:0] out_move_ms;

  intent_scoreboard sb;
  logic [7:0]       text_bytes [$];
  int               in_idle_pct;
  int               out_idle_pct;
  int               bytes_fed;

  keyword_intent_matcher_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_motion_code (out_motion_code),
    .out_speed_pct   (out_speed_pct),
    .out_move_ms     (out_move_ms)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The receiver stalls at random, changing its mind at each falling edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_intent({out_event_code, out_motion_code, out_speed_pct,
                       out_move_ms});
    end
  end

  // Offer one byte from a falling edge and hold it until its transfer.
  task automatic send_byte(logic [7:0] raw, logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = raw;
    in_is_last   = last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(raw, last);
    @(negedge clk);
  endtask

  // Send the composed text; bytes after the terminating zero are not counted.
  task automatic send_text();
    bit ended;
    ended = 1'b0;
    foreach (text_bytes[i]) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
      if (!ended) begin
        bytes_fed++;
      end
      if (text_bytes[i] == 8'h00) begin
        ended = 1'b1;
      end
    end
  endtask

  task automatic load_string(string s);
    text_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      text_bytes.push_back(8'(s[i]));
    end
  endtask

  // Upper-case a letter now and then.
  function automatic logic [7:0] mix_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) begin
      return c - CH_CASE_OFS;
    end
    return c;
  endfunction

  // Mostly phrases of keywords, fragments and filler; the rest raw noise.
  task automatic compose_text();
    string kw;
    int    n;
    int    pos;
    text_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        kw = sb.kw_word[$urandom_range(0, KW_COUNT - 1)];
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            for (int i = 0; i < kw.len(); i++) text_bytes.push_back(mix_case(kw[i]));
          end
          3: begin
            n = $urandom_range(1, kw.len() - 1);
            for (int i = 0; i < n; i++) text_bytes.push_back(mix_case(kw[i]));
          end
          4: begin
            // A keyword with one letter replaced.
            pos = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < kw.len(); i++) begin
              if (i == pos) begin
                text_bytes.push_back(8'("a" + $urandom_range(0, 25)));
              end else begin
                text_bytes.push_back(mix_case(kw[i]));
              end
            end
          end
          default: begin
            repeat ($urandom_range(1, 6)) begin
              text_bytes.push_back(mix_case(8'("a" + $urandom_range(0, 25))));
            end
          end
        endcase
        case ($urandom_range(0, 5))
          0: text_bytes.push_back(" ");
          1: text_bytes.push_back(",");
          2: text_bytes.push_back(8'($urandom_range(1, 255)));
          default: begin
          end
        endcase
      end
      // Early end of text, followed by bytes that must be ignored.
      if ($urandom_range(0, 7) == 0) begin
        text_bytes.push_back(8'h00);
        kw = sb.kw_word[$urandom_range(0, KW_COUNT - 1)];
        for (int i = 0; i < kw.len(); i++) text_bytes.push_back(8'(kw[i]));
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      text_bytes.push_back(8'h00);
    end
  endtask

  // Directed texts, then three idling phases of random texts, then drain.
  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'h00;
    in_is_last   = 1'b0;
    in_idle_pct  = 6;
    out_idle_pct = 51;
    bytes_fed    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Upper case, with the keyword completed by the last byte itself.
    load_string("STOP");
    send_text();
    // Longest keyword fills the whole window.
    load_string("zuozhuan");
    send_text();
    // A keyword tail cannot match across the start of the text.
    load_string("eft");
    send_text();
    // A keyword after the terminating zero is ignored.
    load_string("back");
    text_bytes.push_front(8'h00);
    send_text();
    // Neighbours of the upper-case range and a high byte.
    load_string("@[");
    text_bytes.push_back(8'hFF);
    send_text();
    // A text made of nothing but its terminator.
    text_bytes = '{8'h00};
    send_text();

    while (bytes_fed < 500) begin
      compose_text();
      send_text();
    end
    in_idle_pct  = 51;
    out_idle_pct = 6;
    while (bytes_fed < 1000) begin
      compose_text();
      send_text();
    end
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (bytes_fed < 1500) begin
      compose_text();
      send_text();
    end
    in_valid = 1'b0;

    while (sb.pending_intents.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_keyword_intent_matcher_unit passed");
    end else begin
      $display("tb_keyword_intent_matcher_unit failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #400_000;
    $display("tb_keyword_intent_matcher_unit failed");
    $finish;
  end

endmodule
